[rtl/dwsa_pkg.sv]
// Shared types and codes of the diamond window sum and maximum search block.
package dwsa_pkg;

    // Result kinds, as carried on the master-side tuser.
    localparam logic [1:0] KIND_SUMMARY = 2'd0;
    localparam logic [1:0] KIND_POS     = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_ROWS   = 2'd0;
    localparam logic [1:0] REG_COLS   = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    // Raw register contents plus a pulse that marks an accepted write.
    typedef struct packed {
        logic       wr;
        logic [7:0] rows;
        logic [7:0] cols;
        logic [4:0] radius;
    } t_cfg;

endpackage

[rtl/dwsa_cfg.sv]
// Configuration register file behind the APB-style port.
module dwsa_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [3:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output logic [31:0]        o_prdata,
    output logic               o_pready,
    output dwsa_pkg::t_cfg     o_cfg
);

    logic [7:0] r_rows;
    logic [7:0] r_cols;
    logic [4:0] r_radius;
    logic       w_wr;
    logic       w_hit;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel & i_penable & i_pwrite;

    always_comb begin
        w_hit    = 1'b0;
        o_prdata = 32'd0;
        case (i_paddr[3:2])
            dwsa_pkg::REG_ROWS: begin
                w_hit    = 1'b1;
                o_prdata = {24'd0, r_rows};
            end
            dwsa_pkg::REG_COLS: begin
                w_hit    = 1'b1;
                o_prdata = {24'd0, r_cols};
            end
            dwsa_pkg::REG_RADIUS: begin
                w_hit    = 1'b1;
                o_prdata = {27'd0, r_radius};
            end
            default: begin
                w_hit    = 1'b0;
                o_prdata = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= 8'd1;
            r_cols   <= 8'd1;
            r_radius <= 5'd1;
        end else if (w_wr) begin
            case (i_paddr[3:2])
                dwsa_pkg::REG_ROWS:   r_rows   <= i_pwdata[7:0];
                dwsa_pkg::REG_COLS:   r_cols   <= i_pwdata[7:0];
                dwsa_pkg::REG_RADIUS: r_radius <= i_pwdata[4:0];
                default: ;
            endcase
        end
    end

    // The write pulse is seen in the same cycle the register is written.
    assign o_cfg.wr     = w_wr & w_hit;
    assign o_cfg.rows   = r_rows;
    assign o_cfg.cols   = r_cols;
    assign o_cfg.radius = r_radius;

endmodule

[rtl/diamond_window_sum_argmax.sv]
// Top level of the diamond window sum and maximum search block.
//
// Usage: program rows, cols and radius through the APB-style port while the
// block is idle, then stream the grid in row-major order as slave-side
// transactions with tuser (func) low and the value in tdata. Each load gives
// no result. While values arrive, each row is turned into running prefix
// sums held in the prefix memory. After the last value the block runs its
// sum pass: for each cell and each grid row inside the window it reads two
// prefix entries from the single-port prefix memory and adds one horizontal
// segment, and it writes the saturated sum into the sum memory while
// tracking the maximum. Slave-side tready stays low during the pass.
// Transactions with tuser high fetch results: first the maximum and its
// count, then each maximal cell position (tlast marks the final one), then
// "nothing left". A fetch walks the sum memory to the next maximal cell,
// then places its result in the output register; a new transaction is
// taken while that result waits, so a master side stall only holds the
// block once a second result is ready to go. Reset (synchronous, active
// low) sets the registers to 1 and starts loading at cell 0; the memories
// hold no reset value and need no clearing pass.
module diamond_window_sum_argmax #(
    parameter int MAX_ROWS   = 128,
    parameter int MAX_COLS   = 128,
    parameter int MAX_RADIUS = 31,
    parameter int VALUE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    // Slave side.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] cell_value
    input  logic        i_s_tuser,   // [0] func
    // Master side.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [31:0] max_sum, [46:32] max_count,
                                     // [54:47] pos_row, [62:55] pos_col
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast    // last
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int COLW  = $clog2(MAX_COLS + 1);
    localparam int RADW  = $clog2(MAX_RADIUS + 2);
    localparam int XW0   = (RW > COLW) ? RW : COLW;
    localparam int XW    = ((XW0 > RADW) ? XW0 : RADW) + 2;
    localparam int RNW   = $clog2(MAX_RADIUS * MAX_COLS + 1) + 1;
    localparam int BW    = (CW > RNW) ? CW : RNW;
    localparam int PW    = VALUE_BITS + COLW;
    localparam int ACW   = PW + $clog2(2 * MAX_RADIUS + 2);
    localparam int ACW2  = (ACW > 33) ? ACW : 33;

    typedef enum logic [1:0] {
        PH_LOAD, PH_SUMMARY, PH_POS, PH_DONE
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_CELL, S_HI, S_LO, S_ACC, S_SCAN_RD, S_SCAN_CMP, S_EMIT
    } t_state;

    dwsa_pkg::t_cfg w_cfg;

    dwsa_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    // Geometry in use, saturated to the supported range.
    logic [RW-1:0]   w_nr;
    logic [COLW-1:0] w_nc;
    logic [RADW-1:0] w_rad;
    logic [CW-1:0]   w_total;

    always_comb begin
        if (w_cfg.rows == 8'd0)            w_nr = RW'(1);
        else if (w_cfg.rows > MAX_ROWS)    w_nr = RW'(MAX_ROWS);
        else                               w_nr = RW'(w_cfg.rows);
        if (w_cfg.cols == 8'd0)            w_nc = COLW'(1);
        else if (w_cfg.cols > MAX_COLS)    w_nc = COLW'(MAX_COLS);
        else                               w_nc = COLW'(w_cfg.cols);
        if (w_cfg.radius > MAX_RADIUS)     w_rad = RADW'(MAX_RADIUS);
        else                               w_rad = RADW'(w_cfg.radius);
    end

    assign w_total = CW'(CW'(w_nr) * CW'(w_nc));

    // Control and payload registers.
    t_state          r_state;
    t_phase          r_phase;
    logic [CW-1:0]   r_lidx;
    logic [COLW-1:0] r_lcol;
    logic [PW-1:0]   r_rsum;
    logic [BW-1:0]   r_radnc;
    logic [RW-1:0]   r_tr;
    logic [COLW-1:0] r_tc;
    logic [CW-1:0]   r_tbase;
    logic [CW-1:0]   r_cidx;
    logic [RW-1:0]   r_sr;
    logic [CW-1:0]   r_sbase;
    logic [COLW-1:0] r_lo;
    logic [PW-1:0]   r_hiv;
    logic [ACW2-1:0] r_acc;
    logic [31:0]     r_best_sum;
    logic [CW-1:0]   r_best_count;
    logic [CW-1:0]   r_fidx;
    logic [RW-1:0]   r_frow;
    logic [COLW-1:0] r_fcol;
    logic            r_scan_pos;
    logic [1:0]      r_p_kind;
    logic [31:0]     r_p_sum;
    logic [14:0]     r_p_cnt;
    logic [7:0]      r_p_row;
    logic [7:0]      r_p_col;
    logic            r_o_valid;
    logic [1:0]      r_o_kind;
    logic [31:0]     r_o_sum;
    logic [14:0]     r_o_cnt;
    logic [7:0]      r_o_row;
    logic [7:0]      r_o_col;
    logic            r_o_last;

    // Memories: row prefix sums and window sums.
    logic [PW-1:0]   r_pmem [CELLS];
    logic [31:0]     r_smem [CELLS];
    logic [PW-1:0]   r_prd;
    logic [31:0]     r_srd;

    logic            w_in_acc;
    logic [31:0]     w_ext;
    logic [VALUE_BITS-1:0] w_val;
    logic [CW-1:0]   w_li;
    logic [COLW-1:0] w_lc;
    logic [PW-1:0]   w_pref;
    logic            w_pf_we;
    logic [AW-1:0]   w_pf_raddr;
    logic            w_sm_we;
    logic [31:0]     w_sat;

    // Window geometry for the current target cell and source row.
    logic [XW-1:0]   w_tr_x;
    logic [XW-1:0]   w_tc_x;
    logic [XW-1:0]   w_sr_x;
    logic [XW-1:0]   w_rad_x;
    logic [XW-1:0]   w_nr_x;
    logic [XW-1:0]   w_nc_x;
    logic [RW-1:0]   w_slo;
    logic [RW-1:0]   w_shi;
    logic [XW-1:0]   w_span;
    logic [COLW-1:0] w_hi;
    logic [COLW-1:0] w_lo;
    logic [PW-1:0]   w_seg;
    logic [ACW2-1:0] w_acc_n;

    assign w_in_acc = i_s_tvalid & o_s_tready;
    assign w_ext    = {16'd0, i_s_tdata};
    assign w_val    = w_ext[VALUE_BITS-1:0];
    assign w_li     = (r_phase == PH_LOAD) ? r_lidx : '0;
    assign w_lc     = (r_phase == PH_LOAD) ? r_lcol : '0;
    assign w_pref   = (w_lc == '0) ? PW'(w_val) : r_rsum + PW'(w_val);
    assign w_pf_we  = (r_state == S_IDLE) && w_in_acc && !i_s_tuser;

    always_comb begin
        w_tr_x  = XW'(r_tr);
        w_tc_x  = XW'(r_tc);
        w_sr_x  = XW'(r_sr);
        w_rad_x = XW'(w_rad);
        w_nr_x  = XW'(w_nr);
        w_nc_x  = XW'(w_nc);
        w_slo   = (w_tr_x >= w_rad_x) ? RW'(w_tr_x - w_rad_x) : '0;
        w_shi   = (w_tr_x + w_rad_x > w_nr_x - XW'(1)) ? RW'(w_nr_x - XW'(1))
                                                       : RW'(w_tr_x + w_rad_x);
        w_span  = (w_sr_x >= w_tr_x) ? w_rad_x - (w_sr_x - w_tr_x)
                                     : w_rad_x - (w_tr_x - w_sr_x);
        w_hi    = (w_tc_x + w_span > w_nc_x - XW'(1)) ? COLW'(w_nc_x - XW'(1))
                                                      : COLW'(w_tc_x + w_span);
        w_lo    = (w_tc_x >= w_span) ? COLW'(w_tc_x - w_span) : '0;
        w_seg   = r_hiv - ((r_lo != '0) ? r_prd : '0);
        w_acc_n = r_acc + ACW2'(w_seg);
        w_sat   = (|w_acc_n[ACW2-1:32]) ? 32'hFFFF_FFFF : w_acc_n[31:0];
    end

    // The high end of the segment is read first, then the entry left of it.
    assign w_pf_raddr = (r_state == S_HI) ? AW'(r_sbase + CW'(w_hi))
                                          : AW'(r_sbase + CW'(r_lo) - CW'(1));
    assign w_sm_we    = (r_state == S_ACC) && (r_sr == w_shi);

    always_ff @(posedge i_clk) begin
        if (w_pf_we) begin
            r_pmem[AW'(w_li)] <= w_pref;
        end
        r_prd <= r_pmem[w_pf_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_sm_we) begin
            r_smem[AW'(r_cidx)] <= w_sat;
        end
        r_srd <= r_smem[AW'(r_fidx)];
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_LOAD;
            r_lidx       <= '0;
            r_lcol       <= '0;
            r_best_sum   <= '0;
            r_best_count <= '0;
            r_fidx       <= '0;
            r_frow       <= '0;
            r_fcol       <= '0;
            r_scan_pos   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            // The output register empties on a taken transaction unless a new
            // result moves in at the same edge.
            if (r_o_valid && i_m_tready && (r_state != S_EMIT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_cfg.wr) begin
                        r_phase <= PH_LOAD;
                        r_lidx  <= '0;
                        r_lcol  <= '0;
                    end else if (w_in_acc && !i_s_tuser) begin
                        r_phase <= PH_LOAD;
                        r_rsum  <= w_pref;
                        r_lidx  <= w_li + CW'(1);
                        r_lcol  <= (w_lc == w_nc - COLW'(1)) ? '0 : w_lc + COLW'(1);
                        if (w_li + CW'(1) >= w_total) begin
                            r_state <= S_INIT;
                        end
                    end else if (w_in_acc) begin
                        case (r_phase)
                            PH_SUMMARY: begin
                                r_p_kind   <= dwsa_pkg::KIND_SUMMARY;
                                r_p_sum    <= r_best_sum;
                                r_p_cnt    <= 15'(r_best_count);
                                r_p_row    <= '0;
                                r_p_col    <= '0;
                                r_scan_pos <= 1'b0;
                                r_phase    <= PH_POS;
                                r_state    <= S_SCAN_RD;
                            end
                            PH_POS: begin
                                r_p_sum <= '0;
                                r_p_cnt <= '0;
                                if (r_fidx >= w_total) begin
                                    r_p_kind   <= dwsa_pkg::KIND_NONE;
                                    r_p_row    <= '0;
                                    r_p_col    <= '0;
                                    r_scan_pos <= 1'b0;
                                    r_phase    <= PH_DONE;
                                    r_state    <= S_EMIT;
                                end else begin
                                    r_p_kind   <= dwsa_pkg::KIND_POS;
                                    r_p_row    <= 8'(r_frow + RW'(1));
                                    r_p_col    <= 8'(r_fcol + COLW'(1));
                                    r_scan_pos <= 1'b1;
                                    r_fidx     <= r_fidx + CW'(1);
                                    if (r_fcol == w_nc - COLW'(1)) begin
                                        r_fcol <= '0;
                                        r_frow <= r_frow + RW'(1);
                                    end else begin
                                        r_fcol <= r_fcol + COLW'(1);
                                    end
                                    r_state <= S_SCAN_RD;
                                end
                            end
                            default: begin
                                r_p_kind   <= dwsa_pkg::KIND_NONE;
                                r_p_sum    <= '0;
                                r_p_cnt    <= '0;
                                r_p_row    <= '0;
                                r_p_col    <= '0;
                                r_scan_pos <= 1'b0;
                                r_state    <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_INIT: begin
                    r_radnc <= BW'(BW'(w_rad) * BW'(w_nc));
                    r_tr    <= '0;
                    r_tc    <= '0;
                    r_tbase <= '0;
                    r_cidx  <= '0;
                    r_state <= S_CELL;
                end
                S_CELL: begin
                    r_sr    <= w_slo;
                    r_sbase <= (w_tr_x >= w_rad_x) ? CW'(BW'(r_tbase) - r_radnc) : '0;
                    r_acc   <= '0;
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_lo    <= w_lo;
                    r_state <= S_LO;
                end
                S_LO: begin
                    r_hiv   <= r_prd;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= w_acc_n;
                    if (r_sr == w_shi) begin
                        if (r_cidx == '0 || w_sat > r_best_sum) begin
                            r_best_sum   <= w_sat;
                            r_best_count <= CW'(1);
                        end else if (w_sat == r_best_sum) begin
                            r_best_count <= r_best_count + CW'(1);
                        end
                        if (r_cidx == w_total - CW'(1)) begin
                            r_phase <= PH_SUMMARY;
                            r_fidx  <= '0;
                            r_frow  <= '0;
                            r_fcol  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_cidx <= r_cidx + CW'(1);
                            if (r_tc == w_nc - COLW'(1)) begin
                                r_tc    <= '0;
                                r_tr    <= r_tr + RW'(1);
                                r_tbase <= r_tbase + CW'(w_nc);
                            end else begin
                                r_tc <= r_tc + COLW'(1);
                            end
                            r_state <= S_CELL;
                        end
                    end else begin
                        r_sr    <= r_sr + RW'(1);
                        r_sbase <= r_sbase + CW'(w_nc);
                        r_state <= S_HI;
                    end
                end
                S_SCAN_RD: begin
                    r_state <= (r_fidx >= w_total) ? S_EMIT : S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    if (r_srd == r_best_sum) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_fidx <= r_fidx + CW'(1);
                        if (r_fcol == w_nc - COLW'(1)) begin
                            r_fcol <= '0;
                            r_frow <= r_frow + RW'(1);
                        end else begin
                            r_fcol <= r_fcol + COLW'(1);
                        end
                        r_state <= S_SCAN_RD;
                    end
                end
                S_EMIT: begin
                    if (!r_o_valid || i_m_tready) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= r_p_kind;
                        r_o_sum   <= r_p_sum;
                        r_o_cnt   <= r_p_cnt;
                        r_o_row   <= r_p_row;
                        r_o_col   <= r_p_col;
                        r_o_last  <= r_scan_pos && (r_fidx >= w_total);
                        if (r_scan_pos && (r_fidx >= w_total)) begin
                            r_phase <= PH_DONE;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {1'b0, r_o_col, r_o_row, r_o_cnt, r_o_sum};
    assign o_m_tuser  = r_o_kind;
    assign o_m_tlast  = r_o_last;

    // A register write while idle restarts loading at the first cell.
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg.wr && r_state == S_IDLE) |=> (r_phase == PH_LOAD && r_lidx == '0))
        else $error("register write did not restart loading");

    // Only a position result may carry the final marker.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tuser == dwsa_pkg::KIND_POS))
        else $error("final marker on a result that is not a position");

    // Once a sum pass has finished, at least one and at most all cells are maximal.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_LOAD) |-> (r_best_count != '0 && r_best_count <= w_total))
        else $error("maximum count out of range");

    // The fetch cursor never runs past the end of the grid.
    a_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_POS) |-> (r_fidx <= w_total))
        else $error("fetch cursor past the end of the grid");

endmodule

[tb/sv/testbench.sv]
// Testbench for the diamond window sum and maximum search block.
`timescale 1ns / 100ps

// Result fields as they travel on the master side.
typedef struct {
    logic [1:0]  kind;
    logic [31:0] max_sum;
    logic [14:0] max_count;
    logic [7:0]  pos_row;
    logic [7:0]  pos_col;
    logic        last;
} t_window_result;

typedef enum logic [1:0] {
    GRID_LOADING, GRID_SUMMARY, GRID_POSITIONS, GRID_EXHAUSTED
} t_grid_phase;

// Predicts the window sums and the readout order, and holds the results
// that are still owed by the block.
class window_scoreboard;
    localparam int ROWS_MAX = 128;
    localparam int COLS_MAX = 128;
    localparam int RAD_MAX  = 31;

    logic [7:0]  reg_rows = 8'd1;
    logic [7:0]  reg_cols = 8'd1;
    logic [4:0]  reg_radius = 5'd1;
    int unsigned grid [ROWS_MAX*COLS_MAX];
    logic [31:0] sums [ROWS_MAX*COLS_MAX];
    int unsigned load_idx = 0;
    int unsigned fetch_idx = 0;
    logic [31:0] best = 0;
    int unsigned best_cnt = 0;
    t_grid_phase phase = GRID_LOADING;
    t_window_result owed [$];
    int errors = 0;

    function int unsigned n_rows();
        return (reg_rows < 1) ? 1 : ((reg_rows > ROWS_MAX) ? ROWS_MAX : reg_rows);
    endfunction

    function int unsigned n_cols();
        return (reg_cols < 1) ? 1 : ((reg_cols > COLS_MAX) ? COLS_MAX : reg_cols);
    endfunction

    function void write_reg(int unsigned idx, logic [31:0] data);
        if (idx == dwsa_pkg::REG_ROWS) reg_rows = data[7:0];
        else if (idx == dwsa_pkg::REG_COLS) reg_cols = data[7:0];
        else if (idx == dwsa_pkg::REG_RADIUS) reg_radius = data[4:0];
        else return;
        phase = GRID_LOADING;
        load_idx = 0;
    endfunction

    // Straight summation over the diamond, using one prefix sum per row.
    function void sum_windows();
        int nr, nc, rad, span, lo, hi, tr;
        longint unsigned row_pre [ROWS_MAX][COLS_MAX+1];
        longint unsigned acc;
        logic [31:0] s;
        nr = n_rows();
        nc = n_cols();
        rad = (reg_radius > RAD_MAX) ? RAD_MAX : reg_radius;
        for (int r = 0; r < nr; r++) begin
            row_pre[r][0] = 0;
            for (int c = 0; c < nc; c++)
                row_pre[r][c+1] = row_pre[r][c] + grid[r*nc+c];
        end
        best = 0;
        best_cnt = 0;
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                acc = 0;
                for (int dr = -rad; dr <= rad; dr++) begin
                    tr = r + dr;
                    if (tr >= 0 && tr < nr) begin
                        span = rad - ((dr < 0) ? -dr : dr);
                        lo = (c - span < 0) ? 0 : c - span;
                        hi = (c + span > nc - 1) ? nc - 1 : c + span;
                        acc += row_pre[tr][hi+1] - row_pre[tr][lo];
                    end
                end
                s = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
                sums[r*nc+c] = s;
                if ((r == 0 && c == 0) || s > best) begin
                    best = s;
                    best_cnt = 1;
                end else if (s == best) begin
                    best_cnt++;
                end
            end
        end
    endfunction

    function int unsigned next_peak(int unsigned start);
        int unsigned total;
        total = n_rows() * n_cols();
        while (start < total && sums[start] != best) start++;
        return start;
    endfunction

    // Called for every accepted slave-side transaction.
    function void note_input(logic func, logic [15:0] value);
        int unsigned total, nxt;
        t_window_result res;
        total = n_rows() * n_cols();
        if (func == 1'b0) begin
            if (phase != GRID_LOADING) begin
                phase = GRID_LOADING;
                load_idx = 0;
            end
            if (load_idx < total) grid[load_idx] = value;
            load_idx++;
            if (load_idx >= total) begin
                sum_windows();
                phase = GRID_SUMMARY;
                fetch_idx = 0;
            end
            return;
        end
        res = '{dwsa_pkg::KIND_NONE, 0, 0, 0, 0, 0};
        if (phase == GRID_SUMMARY) begin
            res.kind = dwsa_pkg::KIND_SUMMARY;
            res.max_sum = best;
            res.max_count = best_cnt[14:0];
            fetch_idx = next_peak(0);
            phase = GRID_POSITIONS;
        end else if (phase == GRID_POSITIONS) begin
            if (fetch_idx >= total) begin
                phase = GRID_EXHAUSTED;
            end else begin
                res.kind = dwsa_pkg::KIND_POS;
                res.pos_row = fetch_idx / n_cols() + 1;
                res.pos_col = fetch_idx % n_cols() + 1;
                nxt = next_peak(fetch_idx + 1);
                if (nxt >= total) begin
                    res.last = 1'b1;
                    phase = GRID_EXHAUSTED;
                end
                fetch_idx = nxt;
            end
        end
        owed.push_back(res);
    endfunction

    // Called for every accepted master-side transaction.
    function void check_result(t_window_result got);
        t_window_result exp;
        if (owed.size() == 0) begin
            $error("result kind %0d arrived with nothing expected", got.kind);
            errors++;
            return;
        end
        exp = owed.pop_front();
        if (got.kind !== exp.kind) begin
            $error("kind: expected %0d, got %0d", exp.kind, got.kind);
            errors++;
        end
        if (got.max_sum !== exp.max_sum) begin
            $error("max_sum: expected %0d, got %0d", exp.max_sum, got.max_sum);
            errors++;
        end
        if (got.max_count !== exp.max_count) begin
            $error("max_count: expected %0d, got %0d", exp.max_count, got.max_count);
            errors++;
        end
        if (got.pos_row !== exp.pos_row) begin
            $error("pos_row: expected %0d, got %0d", exp.pos_row, got.pos_row);
            errors++;
        end
        if (got.pos_col !== exp.pos_col) begin
            $error("pos_col: expected %0d, got %0d", exp.pos_col, got.pos_col);
            errors++;
        end
        if (got.last !== exp.last) begin
            $error("last: expected %0d, got %0d", exp.last, got.last);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int STALL_LIMIT = 100000;  // cycles without any transaction
    localparam int HOLD_CYCLES = 300;     // long receiver hold-off
    localparam int SETTLE      = 40;      // cycles after the block looks idle

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_psel = 1'b0;
    logic        i_penable = 1'b0;
    logic        i_pwrite = 1'b0;
    logic [3:0]  i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic        o_pready;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;   // [15:0] cell_value
    logic        i_s_tuser = 1'b0; // [0] func
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;        // [31:0] max_sum, [46:32] max_count,
                                   // [54:47] pos_row, [62:55] pos_col
    logic [1:0]  o_m_tuser;        // [1:0] kind
    logic        o_m_tlast;

    window_scoreboard sb = new();

    // Idle percentages of the current phase, and the request for a long hold-off.
    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    bit hold_req = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    diamond_window_sum_argmax i_dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls by phase, plus the long hold-off that lets the
    // block fill up and push back on its slave side.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // Every accepted result goes straight to the scoreboard.
    always @(posedge i_clk) begin
        t_window_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind = o_m_tuser;
            got.max_sum = o_m_tdata[31:0];
            got.max_count = o_m_tdata[46:32];
            got.pos_row = o_m_tdata[54:47];
            got.pos_col = o_m_tdata[62:55];
            got.last = o_m_tlast;
            sb.check_result(got);
        end
    end

    // A run that stops moving ends here.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // Offers one transaction and returns at the edge where it is taken.
    task automatic send_item(input logic func, input logic [15:0] value);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= func;
        i_s_tdata <= value;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_input(func, value);
        items_sent++;
    endtask

    // Waits until every owed result is in and the sum pass has finished.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0 || !o_s_tready) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge that ends the access cycle.
    task automatic write_reg(input int unsigned idx, input logic [31:0] data);
        wait_idle();
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= 4'(idx * 4);
        i_pwdata <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
    endtask

    function automatic logic [15:0] pick_value(int spread);
        case (spread)
            0: return 16'($urandom);
            1: return 16'($urandom_range(1));
            2: return 16'hFFFF;
            default: return 16'($urandom_range(3));
        endcase
    endfunction

    // One grid: program the registers, load every cell, then fetch.
    // Fetch noise during the load and a cut-off load are mixed in on request.
    task automatic run_grid(input logic [31:0] nr, input logic [31:0] nc,
                            input logic [31:0] rad, input int spread,
                            input int extra_fetches, input bit noisy);
        int unsigned total;
        write_reg(dwsa_pkg::REG_ROWS, nr);
        write_reg(dwsa_pkg::REG_COLS, nc);
        write_reg(dwsa_pkg::REG_RADIUS, rad);
        total = sb.n_rows() * sb.n_cols();
        // A broken load that a fresh grid overwrites after a fetch.
        if (noisy && $urandom_range(2) == 0) begin
            repeat ($urandom_range(total)) send_item(1'b0, pick_value(spread));
            send_item(1'b1, 16'($urandom));
            if (sb.phase != GRID_LOADING) send_item(1'b1, 16'($urandom));
        end
        while (sb.phase != GRID_SUMMARY) begin
            if (noisy && $urandom_range(9) == 0) send_item(1'b1, 16'($urandom));
            send_item(1'b0, pick_value(spread));
        end
        repeat (sb.best_cnt + 1 + extra_fetches) send_item(1'b1, 16'($urandom));
    endtask

    initial begin
        int job;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: a fetch before anything is loaded, then a 1x1 grid.
        send_item(1'b1, 16'h0000);
        send_item(1'b0, 16'hFFFF);
        repeat (4) send_item(1'b1, 16'hFFFF);
        // A load after results starts a fresh grid at once.
        send_item(1'b0, 16'h0000);
        send_item(1'b1, 16'h5555);
        send_item(1'b1, 16'hAAAA);
        // Radius zero with all values equal: every cell is maximal.
        run_grid(2, 3, 0, 2, 1, 0);
        // Out-of-range register values saturate, and index three is ignored.
        run_grid(0, 2, 32'hFFFF_FFE0, 0, 1, 0);
        write_reg(3, 32'hFFFF_FFFF);
        send_item(1'b1, 16'h0001);
        // Radius at its top covers the whole small grid.
        run_grid(3, 2, 31, 1, 1, 0);

        // Largest single dimensions, with saturation of the other register.
        run_grid(255, 1, 31, 0, 1, 0);
        run_grid(1, 128, 31, 3, 1, 0);

        // Random part: the idle style changes every grid.
        job = 0;
        while (items_sent < 1450) begin
            case (job % 4)
                0: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
                1: begin snd_idle_pct = 58; rcv_stall_pct = 0; end
                2: begin snd_idle_pct = 0; rcv_stall_pct = 58; end
                default: begin snd_idle_pct = 15; rcv_stall_pct = 15; end
            endcase
            if (job == 5) begin
                // Long hold-off while fetches keep coming.
                wait_idle();
                hold_req = 1;
                run_grid(2, 2, 1, 3, 8, 0);
            end else if (job % 40 == 39) begin
                run_grid($urandom_range(16, 128), 1, $urandom_range(31),
                         $urandom_range(3), 1, 1);
            end else begin
                run_grid($urandom_range(1, 8), $urandom_range(1, 8),
                         ($urandom_range(3) == 0) ? 31 : $urandom_range(6),
                         $urandom_range(3), $urandom_range(2), 1);
            end
            job++;
        end

        wait_idle();
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/dwsa_pkg.sv
rtl/dwsa_cfg.sv
rtl/diamond_window_sum_argmax.sv
tb/sv/testbench.sv
